/* rtl/core/efws_pkg.sv */
// ----------------------------------------------------------------------------
// efws_pkg: shared types and constants for the earliest-free-worker scheduler
// Field widths, reset values and the saturating time adder used by the cells.
// ----------------------------------------------------------------------------
`default_nettype none

package efws_pkg;

    localparam int NUM_WORKERS_DEF = 16;   // default number of worker cells
    localparam int COUNT_W         = 5;    // worker_count register width
    localparam int DUR_W           = 32;   // job duration width
    localparam int TIME_W          = 64;   // free time / start time width
    localparam int OUT_IDX_W       = 4;    // reported worker index width

    localparam logic [COUNT_W-1:0] COUNT_RST = COUNT_W'(16);

    // Update broadcast from the chain tail to every cell.
    typedef struct packed {
        logic             en;
        logic [DUR_W-1:0] dur;
    } t_upd;

    // Free time plus duration, pinned at all ones on overflow.
    function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                  input logic [DUR_W-1:0]  b);
        logic [TIME_W:0] sum;
        sum = {1'b0, a} + {{(TIME_W-DUR_W+1){1'b0}}, b};
        return sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
    endfunction

endpackage

`default_nettype wire

/* rtl/core/efws_cell.sv */
// ----------------------------------------------------------------------------
// efws_cell: one worker of the scheduler chain
// Holds one worker's free time, merges it into the passing min token and
// adds the job duration when the tail picks this worker.
// ----------------------------------------------------------------------------
`default_nettype none

module efws_cell #(
    parameter int IDX_W    = 4,
    parameter int CELL_IDX = 0
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire  [efws_pkg::COUNT_W-1:0]      i_cfg_count,
    input  wire                               i_in_vld,
    input  wire  [efws_pkg::TIME_W-1:0]       i_in_time,
    input  wire  [IDX_W-1:0]                  i_in_idx,
    input  wire                               i_hold,
    input  wire  efws_pkg::t_upd              i_upd,
    input  wire  [IDX_W-1:0]                  i_upd_idx,
    output logic                              o_tok_vld,
    output logic [efws_pkg::TIME_W-1:0]       o_tok_time,
    output logic [IDX_W-1:0]                  o_tok_idx
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    logic [efws_pkg::TIME_W-1:0] r_time;
    logic                        r_vld, n_vld;
    logic [efws_pkg::TIME_W-1:0] r_tok_time;
    logic [IDX_W-1:0]            r_tok_idx;
    logic                        w_part;
    logic                        w_take;

    // worker 0 always takes part; others only below the configured count
    assign w_part = (CELL_IDX == 0) || (int'(i_cfg_count) > CELL_IDX);
    // strict compare keeps the lower index on ties
    assign w_take = w_part && (r_time < i_in_time);

    assign n_vld = i_in_vld | (r_vld & i_hold);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= 1'b0;
            r_time <= '0;
        end else begin
            r_vld <= n_vld;
            if (i_upd.en && (i_upd_idx == MY_IDX)) begin
                r_time <= efws_pkg::sat_add(r_time, i_upd.dur);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_vld) begin
            r_tok_time <= w_take ? r_time : i_in_time;
            r_tok_idx  <= w_take ? MY_IDX : i_in_idx;
        end
    end

    assign o_tok_vld  = r_vld;
    assign o_tok_time = r_tok_time;
    assign o_tok_idx  = r_tok_idx;

endmodule

`default_nettype wire

/* rtl/core/earliest_free_worker_scheduler.sv */
// One request in flight at a time: the min token walks the cell chain from
//   worker 0 to the tail and, once the output register can take it, loads the
//   result there and frees the request side for the next request.
// A waiting result does not block the next request; it only holds the tail.
// Reset: synchronous, active low; free times to zero, worker_count to 16,
//   no clearing pass.
// ----------------------------------------------------------------------------
// earliest_free_worker_scheduler: list scheduler, earliest free worker
// Assigns each job to the active worker with the smallest free time (lowest
// index on ties), reports its start time and books the job's duration.
// ----------------------------------------------------------------------------
`default_nettype none

module earliest_free_worker_scheduler #(
    parameter int NUM_WORKERS = efws_pkg::NUM_WORKERS_DEF
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    // config
    input  wire                                i_cfg_we,
    input  wire  [efws_pkg::COUNT_W-1:0]       i_cfg_wdata,
    // request channel
    input  wire                                i_in_valid,
    output logic                               o_in_stall,
    input  wire  [efws_pkg::DUR_W-1:0]         i_job_duration,
    // result channel
    output logic                               o_out_valid,
    input  wire                                i_out_stall,
    output logic [efws_pkg::OUT_IDX_W-1:0]     o_worker_index,
    output logic [efws_pkg::TIME_W-1:0]        o_start_time
);

    localparam int IDX_W = (NUM_WORKERS > 1) ? $clog2(NUM_WORKERS) : 1;

    // worker_count register
    logic [efws_pkg::COUNT_W-1:0] r_count;

    // one request in flight at a time
    logic                         r_busy;
    logic [efws_pkg::DUR_W-1:0]   r_dur;
    logic                         w_accept;
    logic                         w_fire;

    // token chain: element k is the output of cell k
    logic                         tok_vld  [NUM_WORKERS];
    logic [efws_pkg::TIME_W-1:0]  tok_time [NUM_WORKERS];
    logic [IDX_W-1:0]             tok_idx  [NUM_WORKERS];

    efws_pkg::t_upd               w_upd;

    // output register
    logic                         r_out_vld;
    logic [efws_pkg::OUT_IDX_W-1:0] r_out_idx;
    logic [efws_pkg::TIME_W-1:0]  r_out_time;
    logic [IDX_W+efws_pkg::OUT_IDX_W-1:0] w_idx_ext;

    assign w_accept   = i_in_valid && !r_busy;
    assign o_in_stall = r_busy;

    // tail token completes once the output register can take it
    assign w_fire = tok_vld[NUM_WORKERS-1] && (!r_out_vld || !i_out_stall);

    assign w_upd.en  = w_fire;
    assign w_upd.dur = r_dur;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= efws_pkg::COUNT_RST;
        end else if (i_cfg_we) begin
            r_count <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (w_accept) begin
            r_busy <= 1'b1;
        end else if (w_fire) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_dur <= i_job_duration;
        end
    end

    // Cell 0 sees an all-ones seed; a worker at all ones keeps index 0,
    // which matches the seed, so the result is the same either way.
    genvar g;
    generate
        for (g = 0; g < NUM_WORKERS; g++) begin : g_cell
            if (g == 0) begin : g_head
                efws_cell #(
                    .IDX_W    (IDX_W),
                    .CELL_IDX (g)
                ) u_cell (
                    .i_clk       (i_clk),
                    .i_rst_n     (i_rst_n),
                    .i_cfg_count (r_count),
                    .i_in_vld    (w_accept),
                    .i_in_time   ({efws_pkg::TIME_W{1'b1}}),
                    .i_in_idx    ({IDX_W{1'b0}}),
                    .i_hold      ((NUM_WORKERS == 1) && !w_fire),
                    .i_upd       (w_upd),
                    .i_upd_idx   (tok_idx[NUM_WORKERS-1]),
                    .o_tok_vld   (tok_vld[g]),
                    .o_tok_time  (tok_time[g]),
                    .o_tok_idx   (tok_idx[g])
                );
            end else begin : g_body
                efws_cell #(
                    .IDX_W    (IDX_W),
                    .CELL_IDX (g)
                ) u_cell (
                    .i_clk       (i_clk),
                    .i_rst_n     (i_rst_n),
                    .i_cfg_count (r_count),
                    .i_in_vld    (tok_vld[g-1]),
                    .i_in_time   (tok_time[g-1]),
                    .i_in_idx    (tok_idx[g-1]),
                    .i_hold      ((g == NUM_WORKERS-1) && !w_fire),
                    .i_upd       (w_upd),
                    .i_upd_idx   (tok_idx[NUM_WORKERS-1]),
                    .o_tok_vld   (tok_vld[g]),
                    .o_tok_time  (tok_time[g]),
                    .o_tok_idx   (tok_idx[g])
                );
            end
        end
    endgenerate

    // reported index is the low four bits of the winner
    assign w_idx_ext = {{efws_pkg::OUT_IDX_W{1'b0}}, tok_idx[NUM_WORKERS-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= w_fire | (r_out_vld & i_out_stall);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_idx  <= w_idx_ext[efws_pkg::OUT_IDX_W-1:0];
            r_out_time <= tok_time[NUM_WORKERS-1];
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_worker_index = r_out_idx;
    assign o_start_time   = r_out_time;

endmodule

`default_nettype wire

/* rtl/core/efws_checker.sv */
// ----------------------------------------------------------------------------
// efws_port_checks: port-level checks for the scheduler
// Request/result ordering and result-channel hold behavior.
// ----------------------------------------------------------------------------
`default_nettype none

module efws_port_checks (
    input wire                               i_clk,
    input wire                               i_rst_n,
    input wire                               i_in_valid,
    input wire                               o_in_stall,
    input wire                               o_out_valid,
    input wire                               i_out_stall,
    input wire [efws_pkg::OUT_IDX_W-1:0]     o_worker_index,
    input wire [efws_pkg::TIME_W-1:0]        o_start_time
);

    // an accepted request blocks the next one until its result is out
    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("request accepted while previous one in flight");

    // a fresh result frees the request side
    a_rise_frees_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> !o_in_stall)
        else $error("result issued but request side still stalled");

    // request side only frees up together with a result
    a_free_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_in_stall) |-> o_out_valid)
        else $error("request side freed without a result");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_start_time) && $stable(o_worker_index)))
        else $error("stalled result changed");

endmodule

bind earliest_free_worker_scheduler efws_port_checks u_efws_port_checks (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_worker_index (o_worker_index),
    .o_start_time   (o_start_time)
);

`default_nettype wire

/* tb/efws_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// efws_checker: result checker for the earliest-free-worker scheduler
// Watches the config port and both channels, keeps its own copy of the
// worker free times, predicts each assignment and compares every result.
// ----------------------------------------------------------------------------

module efws_checker #(
    parameter int NUM_WORKERS = efws_pkg::NUM_WORKERS_DEF
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_cfg_we,
    input  wire  [efws_pkg::COUNT_W-1:0]       i_cfg_wdata,
    input  wire                                i_in_valid,
    input  wire                                i_in_stall,
    input  wire  [efws_pkg::DUR_W-1:0]         i_job_duration,
    input  wire                                i_out_valid,
    input  wire                                i_out_stall,
    input  wire  [efws_pkg::OUT_IDX_W-1:0]     i_worker_index,
    input  wire  [efws_pkg::TIME_W-1:0]        i_start_time,
    output int                                 o_open_jobs,
    output int                                 o_fail_count
);

    typedef struct packed {
        logic [efws_pkg::OUT_IDX_W-1:0] worker;
        logic [efws_pkg::TIME_W-1:0]    start;
    } t_assignment;

    logic [efws_pkg::TIME_W-1:0]  free_time [NUM_WORKERS];
    logic [efws_pkg::COUNT_W-1:0] worker_count;
    t_assignment                  booked_q [$];
    t_assignment                  want;
    int                           failures = 0;

    // Pick the earliest free active worker, lowest index on ties, and book the job.
    function automatic t_assignment book_job(input logic [efws_pkg::DUR_W-1:0] dur);
        int                        active;
        int                        pick;
        logic [efws_pkg::TIME_W:0] total;
        t_assignment               a;
        active = (worker_count == 0) ? 1 :
                 (worker_count > NUM_WORKERS) ? NUM_WORKERS : int'(worker_count);
        pick = 0;
        for (int w = 1; w < active; w++) begin
            if (free_time[w] < free_time[pick]) pick = w;
        end
        a.worker = pick[efws_pkg::OUT_IDX_W-1:0];
        a.start  = free_time[pick];
        total    = {1'b0, free_time[pick]} +
                   {{(efws_pkg::TIME_W-efws_pkg::DUR_W+1){1'b0}}, dur};
        free_time[pick] = total[efws_pkg::TIME_W] ? {efws_pkg::TIME_W{1'b1}} :
                                                    total[efws_pkg::TIME_W-1:0];
        return a;
    endfunction

    task automatic flag_error(input string what);
        failures++;
        if (failures <= 10) $display("[%0t] checker: %s", $realtime, what);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (free_time[w]) free_time[w] = '0;
            worker_count = efws_pkg::COUNT_RST;
            booked_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (booked_q.size() == 0) begin
                    flag_error($sformatf("unexpected result: worker %0d start %h",
                                         i_worker_index, i_start_time));
                end else begin
                    want = booked_q.pop_front();
                    if (i_worker_index !== want.worker || i_start_time !== want.start)
                        flag_error($sformatf(
                            "mismatch: worker exp %0d got %0d, start exp %h got %h",
                            want.worker, i_worker_index, want.start, i_start_time));
                end
            end
            if (i_cfg_we) worker_count = i_cfg_wdata;
            if (i_in_valid && !i_in_stall) booked_q.push_back(book_job(i_job_duration));
        end
        o_open_jobs  <= booked_q.size();
        o_fail_count <= failures;
    end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the earliest-free-worker scheduler
// Drives job durations and worker_count settings through several idle and
// stall mixes, including a long result hold-off; efws_checker judges results.
// ----------------------------------------------------------------------------

module tb_top;

    localparam int NWORK       = efws_pkg::NUM_WORKERS_DEF;
    localparam int HOLD_CYCLES = 300;   // long result hold-off, fills the block
    localparam int QUIET_LIMIT = 4000;  // cycles with no handshake before giving up
    localparam int BLOCKS      = 5;     // worker_count settings per random phase
    localparam int BLOCK_ITEMS = 100;

    // Clock and reset
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Block ports
    logic                           cfg_we       = 1'b0;
    logic [efws_pkg::COUNT_W-1:0]   cfg_wdata    = '0;
    logic                           in_valid     = 1'b0;
    logic                           in_stall;
    logic [efws_pkg::DUR_W-1:0]     job_duration = '0;
    logic                           out_valid;
    logic                           out_stall    = 1'b0;
    logic [efws_pkg::OUT_IDX_W-1:0] worker_index;
    logic [efws_pkg::TIME_W-1:0]    start_time;

    // Checker feedback
    int open_jobs;
    int fail_count;

    // Traffic shaping: percent of cycles the sender idles / receiver stalls
    int idle_pct  = 0;
    int stall_pct = 0;

    // Hold-off handshake: stimulus bumps hold_id, the stall process acks it
    int hold_id   = 0;
    int hold_ack  = 0;
    int hold_left = 0;
    int quiet     = 0;

    earliest_free_worker_scheduler #(.NUM_WORKERS(NWORK)) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_wdata    (cfg_wdata),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_job_duration (job_duration),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_worker_index (worker_index),
        .o_start_time   (start_time)
    );

    efws_checker #(.NUM_WORKERS(NWORK)) u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_wdata    (cfg_wdata),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_job_duration (job_duration),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_worker_index (worker_index),
        .i_start_time   (start_time),
        .o_open_jobs    (open_jobs),
        .o_fail_count   (fail_count)
    );

    // Result side: random stall, or a counted hold-off when one is requested.
    // The sender keeps offering during the hold-off, so the block's input
    // backs up and in_stall rises.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else if (hold_ack != hold_id) begin
            hold_ack  <= hold_id;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // Watchdog: any accepted request or result resets the quiet counter
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet <= 0;
        end else if (quiet >= QUIET_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    // Offer one request and return at the edge where it is taken. Valid is
    // only dropped when an idle gap is drawn, so back-to-back requests keep
    // it high without a second assignment in the same step.
    task automatic send_job(input logic [efws_pkg::DUR_W-1:0] dur);
        if ($urandom_range(0, 99) < idle_pct) begin
            in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < idle_pct);
        end
        in_valid     <= 1'b1;
        job_duration <= dur;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
    endtask

    // Drop valid and wait until every booked job has been reported
    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge i_clk); while (open_jobs != 0);
    endtask

    task automatic set_workers(input logic [efws_pkg::COUNT_W-1:0] n);
        cfg_we    <= 1'b1;
        cfg_wdata <= n;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
    endtask

    // Half the draws are short jobs (0 to 1000) so free times collide and ties get exercised
    function automatic logic [efws_pkg::DUR_W-1:0] pick_duration();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2, 3:    return efws_pkg::DUR_W'($urandom_range(0, 15));
            4, 5:    return efws_pkg::DUR_W'($urandom_range(0, 1000));
            default: return efws_pkg::DUR_W'($urandom());
        endcase
    endfunction

    // Includes zero and values above the worker count, both get clamped
    function automatic logic [efws_pkg::COUNT_W-1:0] pick_count();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return efws_pkg::COUNT_W'(1);
            2:       return efws_pkg::COUNT_W'(
                         $urandom_range(NWORK + 1, (1 << efws_pkg::COUNT_W) - 1));
            3:       return efws_pkg::COUNT_W'(NWORK);
            default: return efws_pkg::COUNT_W'($urandom_range(1, NWORK));
        endcase
    endfunction

    task automatic run_phase(input int idle, input int stall, input bit with_hold);
        idle_pct  = idle;
        stall_pct = stall;
        for (int b = 0; b < BLOCKS; b++) begin
            set_workers(pick_count());
            for (int k = 0; k < BLOCK_ITEMS; k++) begin
                if (with_hold && b == 1 && k == 20) hold_id <= hold_id + 1;
                send_job(pick_duration());
            end
            settle();
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset count of 16, all free times tie at zero first,
        // then extreme durations and a few repeats to build ties.
        send_job(32'h0000_0000);
        send_job(32'hFFFF_FFFF);
        send_job(32'h0000_0001);
        send_job(32'h8000_0000);
        send_job(32'h7FFF_FFFF);
        send_job(32'h0000_0000);
        send_job(32'h0000_0005);
        send_job(32'h0000_0005);
        send_job(32'h5555_5555);
        send_job(32'hAAAA_AAAA);
        send_job(32'h0000_0003);
        send_job(32'h0000_0002);
        send_job(32'h0000_0001);
        send_job(32'h0000_0000);
        send_job(32'h0000_0007);
        send_job(32'h0000_0009);
        send_job(32'h0000_0064);
        settle();

        // Count of zero acts as one worker: worker 0 every time
        set_workers('0);
        send_job(32'h0000_0010);
        send_job(32'hFFFF_FFFF);
        settle();

        // Count above the worker total clamps to all workers
        set_workers('1);
        send_job(32'h0000_0004);
        send_job(32'h0000_0000);
        settle();

        // Shrinking the set keeps the excluded workers' free times
        set_workers(efws_pkg::COUNT_W'(1));
        send_job(32'h0000_0020);
        settle();
        set_workers(efws_pkg::COUNT_W'(2));
        send_job(32'h0000_0001);
        send_job(32'h0000_0001);
        settle();

        // Random phases: no idling, sender idle, receiver stall, both
        run_phase(0, 0, 1'b1);
        run_phase(72, 0, 1'b0);
        run_phase(0, 72, 1'b1);
        run_phase(22, 22, 1'b0);

        // Let any trailing activity in the cell chain die out
        repeat (2 * NWORK) @(posedge i_clk);

        if (fail_count == 0 && open_jobs == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/core/efws_pkg.sv
rtl/core/efws_cell.sv
rtl/core/earliest_free_worker_scheduler.sv
rtl/core/efws_checker.sv
tb/efws_checker.sv
tb/tb_top.sv
